/* rtl/ralog_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ralog_pkg
// shared types and constants of the record aligned ring log
// ----------------------------------------------------------------------------
package ralog_pkg;

    localparam int PW = 12;
    localparam int SW = 11;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_OPEN   = 2'd1;
    localparam logic [1:0] CMD_CLOSE  = 2'd2;
    localparam logic [1:0] CMD_RESET  = 2'd3;

    localparam logic [7:0]  MARK       = 8'hAA;
    localparam logic [15:0] LEN_LIMIT  = 16'd1000;
    localparam logic [15:0] LEN_FLOOR  = 16'd10;
    localparam logic [9:0]  SCAN_LIMIT = 10'd500;

    localparam logic       CFG_FIRST = 1'b0;
    localparam logic       CFG_LAST  = 1'b1;

    typedef logic [PW-1:0] t_pos;
    typedef logic [SW-1:0] t_sum;

    // one classified command as it travels from front to back
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        t_pos head;
        t_pos tail;
        t_sum sum_now;
        t_pos head_saved;
        t_pos tail_saved;
        t_sum sum_saved;
        logic evicted;
    } t_res;

    function automatic t_sum cks(input t_pos h, input t_pos t);
        cks = SW'(h[7:0]) + SW'(h[PW-1:8]) + SW'(t[7:0]) + SW'(t[PW-1:8]);
    endfunction

endpackage

/* rtl/ralog_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ralog_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module ralog_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* rtl/ralog_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ralog_front
// intake stage and two entry command queue
// ----------------------------------------------------------------------------
module ralog_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [1:0]       i_command,
    input  logic [7:0]       i_data_byte,
    output logic             o_full,
    output logic             o_valid,
    output ralog_pkg::t_cmd  o_cmd,
    input  logic             i_take
);
    import ralog_pkg::*;

    t_cmd       r_q [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_cnt;
    logic       w_in;
    logic       w_out;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rd];
    assign w_in    = i_push && !o_full;
    assign w_out   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in) begin
                r_wr <= ~r_wr;
            end
            if (w_out) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(w_in) - 2'(w_out);
        end
        if (w_in) begin
            r_q[r_wr] <= '{cmd: i_command, data: i_data_byte};
        end
    end
endmodule

/* rtl/ralog_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ralog_back
// command sequencer: pointer updates, store writes and record eviction
// ----------------------------------------------------------------------------
module ralog_back #(
    parameter int LOG_DEPTH     = 4096,
    parameter int SHIFT_RECORDS = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [11:0]     i_cfg_data,
    input  logic            i_valid,
    input  ralog_pkg::t_cmd i_cmd,
    output logic            o_take,
    output logic            o_res_valid,
    output ralog_pkg::t_res o_res,
    input  logic            i_res_pop
);
    import ralog_pkg::*;

    localparam int AW = $clog2(LOG_DEPTH);
    localparam int RW = $clog2(SHIFT_RECORDS + 1);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_EV    = 4'd2;  // read lo at head
    localparam logic [3:0] S_EVHI  = 4'd3;  // head=nxt, read hi
    localparam logic [3:0] S_LEN   = 4'd4;  // got lo, wait hi
    localparam logic [3:0] S_WALK  = 4'd5;  // walk record body
    localparam logic [3:0] S_CHK1  = 4'd6;  // read b1 at head
    localparam logic [3:0] S_CHK2  = 4'd7;  // read b2 at nxt(head)
    localparam logic [3:0] S_CHK3  = 4'd8;
    localparam logic [3:0] S_SC0   = 4'd9;  // scan: read b1 at head
    localparam logic [3:0] S_SC1   = 4'd10; // scan: read nxt(head)
    localparam logic [3:0] S_SC2   = 4'd11; // scan: test pair
    localparam logic [3:0] S_DONE  = 4'd12;
    localparam logic [3:0] S_SC3   = 4'd13; // scan: read nxt(head) again

    logic [3:0]  r_st;
    t_pos        r_first, r_last;
    t_pos        r_head, r_tail, r_hs, r_ts;
    t_sum        r_sn, r_ss;
    logic [15:0] r_cnt;
    logic [7:0]  r_lo, r_b1;
    logic [9:0]  r_num;
    logic [RW-1:0] r_rec;
    logic [AW:0] r_clr;
    logic        r_full;
    logic        r_evd;
    t_res        r_res;

    logic        w_we;
    logic [AW-1:0] w_addr;
    logic [7:0]  w_wd, w_rd;
    t_pos        w_hn, w_tn, w_hn2;
    logic [15:0] w_len, w_cnt0;
    logic        w_more;
    logic        w_fin;

    function automatic t_pos nxt(input t_pos p, input t_pos f, input t_pos l);
        nxt = (p == l) ? f : p + 1'b1;
    endfunction

    assign w_hn  = nxt(r_head, r_first, r_last);
    assign w_tn  = nxt(r_tail, r_first, r_last);
    assign w_hn2 = nxt(w_hn, r_first, r_last);

    // record length from the two header bytes, minus one when nonzero
    assign w_len  = {w_rd, r_lo};
    assign w_cnt0 = (w_len != 16'd0) ? w_len - 16'd1 : w_len;

    // eviction end: repeat for further records, else retire the word
    assign w_more = (r_st == S_DONE) && r_evd && (32'(r_rec) + 1 < SHIFT_RECORDS);
    assign w_fin  = (r_st == S_DONE) && !w_more && (!r_full || i_res_pop);

    ralog_ram #(.WIDTH(8), .DEPTH(LOG_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wd),
        .o_rdata(w_rd)
    );

    assign o_take      = (r_st == S_IDLE) && i_valid;
    assign o_res_valid = r_full;
    assign o_res       = r_res;

    always_comb begin
        w_we   = 1'b0;
        w_wd   = i_cmd.data;
        w_addr = AW'(r_head);
        case (r_st)
            S_CLR: begin
                w_we   = 1'b1;
                w_wd   = '0;
                w_addr = r_clr[AW-1:0];
            end
            S_IDLE: begin
                w_we   = o_take && (i_cmd.cmd == CMD_APPEND);
                w_addr = AW'(r_tail);
            end
            S_EVHI, S_CHK2, S_SC1, S_SC3: w_addr = AW'(w_hn);
            default: w_addr = AW'(r_head);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_CLR;
            r_clr   <= '0;
            r_first <= '0;
            r_last  <= '1;
            r_head  <= '0;
            r_tail  <= '0;
            r_hs    <= '0;
            r_ts    <= '0;
            r_sn    <= '0;
            r_ss    <= '0;
            r_evd   <= 1'b0;
            r_rec   <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FIRST) begin
                    r_first <= i_cfg_data;
                end else begin
                    r_last <= i_cfg_data;
                end
            end
            case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(LOG_DEPTH - 1)) begin
                        r_st <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_take) begin
                        r_evd <= (i_cmd.cmd == CMD_APPEND) && (w_tn == r_head);
                        r_rec <= '0;
                        case (i_cmd.cmd)
                            CMD_APPEND: begin
                                r_tail <= w_tn;
                                r_st   <= (w_tn == r_head) ? S_EV : S_DONE;
                            end
                            CMD_OPEN: begin
                                r_hs <= r_head;
                                r_ts <= r_tail;
                                r_ss <= r_sn;
                                r_st <= S_DONE;
                            end
                            CMD_CLOSE: begin
                                r_sn <= cks(r_head, r_tail);
                                r_st <= S_DONE;
                            end
                            default: begin
                                r_head <= r_first;
                                r_tail <= r_first;
                                r_hs   <= r_first;
                                r_ts   <= r_first;
                                r_sn   <= '0;
                                r_ss   <= '0;
                                r_st   <= S_DONE;
                            end
                        endcase
                    end
                end
                S_EV: r_st <= S_EVHI;     // ram reads lo at head
                S_EVHI: begin
                    r_lo   <= w_rd;
                    r_head <= w_hn;
                    r_st   <= S_LEN;
                end
                S_LEN: begin
                    // hi byte now in w_rd
                    r_cnt <= w_cnt0;
                    if (w_cnt0 < LEN_LIMIT && w_cnt0 > LEN_FLOOR) begin
                        r_st <= S_WALK;
                    end else begin
                        r_head <= w_hn;
                        r_st   <= S_SC0;
                    end
                end
                S_WALK: begin
                    r_head <= w_hn;
                    r_cnt  <= r_cnt - 16'd1;
                    if (r_cnt == 16'd3) begin
                        r_st <= S_CHK1;
                    end else if (r_tail == w_hn) begin
                        r_st <= S_DONE;
                    end
                end
                S_CHK1: r_st <= S_CHK2;   // ram reads b1
                S_CHK2: begin
                    r_b1 <= w_rd;
                    r_st <= S_CHK3;
                end
                S_CHK3: begin
                    if (r_b1 == MARK && w_rd == MARK) begin
                        r_head <= (r_tail != w_hn) ? w_hn2 : w_hn;
                        r_st   <= S_DONE;
                    end else begin
                        // mismatch: step past both checked bytes, then scan
                        r_head <= w_hn2;
                        r_st   <= S_SC0;
                    end
                end
                S_SC0: r_st <= S_SC1;
                S_SC1: begin
                    r_b1  <= w_rd;
                    r_num <= 10'd1;
                    r_st  <= S_SC2;
                end
                S_SC2: begin
                    if ((r_b1 == MARK && w_rd == MARK) || r_num > SCAN_LIMIT) begin
                        r_head <= (r_tail != w_hn) ? w_hn2 : w_hn;
                        r_st   <= S_DONE;
                    end else begin
                        r_head <= w_hn;
                        if (r_tail == w_hn) begin
                            r_st <= S_DONE;
                        end else begin
                            r_b1  <= w_rd;
                            r_num <= r_num + 1'b1;
                            r_st  <= S_SC3;
                        end
                    end
                end
                S_SC3: r_st <= S_SC2;
                S_DONE: begin
                    if (w_more) begin
                        r_rec <= r_rec + 1'b1;
                        r_st  <= S_EV;
                    end else if (w_fin) begin
                        // eviction refreshes the backup head and checksum
                        if (r_evd) begin
                            r_hs <= r_head;
                            r_ss <= cks(r_head, r_ts);
                        end
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (w_fin) begin
            r_full <= 1'b1;
        end else if (i_res_pop) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_res.head       <= r_head;
            r_res.tail       <= r_tail;
            r_res.sum_now    <= r_sn;
            r_res.head_saved <= r_evd ? r_head : r_hs;
            r_res.tail_saved <= r_ts;
            r_res.sum_saved  <= r_evd ? cks(r_head, r_ts) : r_ss;
            r_res.evicted    <= r_evd;
        end
    end
endmodule

/* rtl/record_aligned_ring_log.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_aligned_ring_log
// circular byte log with record aligned eviction
// ----------------------------------------------------------------------------
// open, close, reset and plain append go from idle to done, where the result is
// registered once the output word is free or popped; the next command waits.
// an evicting append reads the record length, walks the body byte by byte,
// checks the marker pair, and scans on a bad length or pair; log ram is single port.
// reset: synchronous; a clearing pass over all LOG_DEPTH words zeroes the log
// ram, the intake holds up to two words meanwhile and empty stays high.
module record_aligned_ring_log #(
    parameter int LOG_DEPTH     = 4096,
    parameter int SHIFT_RECORDS = 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [11:0] o_head_pos,
    output logic [11:0] o_tail_pos,
    output logic [10:0] o_pointer_sum,
    output logic [11:0] o_backup_head,
    output logic [11:0] o_backup_tail,
    output logic [10:0] o_backup_sum,
    output logic        o_evicted
);
    import ralog_pkg::*;

    logic w_valid, w_take, w_rv;
    t_cmd w_cmd;
    t_res w_res;

    ralog_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_command(i_command),
        .i_data_byte(i_data_byte), .o_full(full), .o_valid(w_valid),
        .o_cmd(w_cmd), .i_take(w_take)
    );

    ralog_back #(.LOG_DEPTH(LOG_DEPTH), .SHIFT_RECORDS(SHIFT_RECORDS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .i_valid(w_valid),
        .i_cmd(w_cmd), .o_take(w_take), .o_res_valid(w_rv), .o_res(w_res),
        .i_res_pop(pop)
    );

    assign empty         = !w_rv;
    assign o_head_pos    = w_res.head;
    assign o_tail_pos    = w_res.tail;
    assign o_pointer_sum = w_res.sum_now;
    assign o_backup_head = w_res.head_saved;
    assign o_backup_tail = w_res.tail_saved;
    assign o_backup_sum  = w_res.sum_saved;
    assign o_evicted     = w_res.evicted;
endmodule

/* rtl/ralog_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ralog_checker
// port level checks of the ring log
// ----------------------------------------------------------------------------
module ralog_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [11:0] o_head_pos,
    input logic [10:0] o_pointer_sum,
    input logic        o_evicted
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_head_pos))
        else $error("result changed while waiting");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result after reset");

    a_ev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_evicted) && $stable(o_pointer_sum))
        else $error("result flags changed while waiting");
endmodule

bind record_aligned_ring_log ralog_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .empty(empty), .pop(pop),
    .o_head_pos(o_head_pos), .o_pointer_sum(o_pointer_sum),
    .o_evicted(o_evicted)
);
